[sv/fskid_pkg.sv]
// Package for the FSK interval demodulator: widths, nominal periods, register codes, window check.
package fskid_pkg;

    localparam int unsigned TICKS_W    = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned TOL_W      = 8;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 8;

    // Bits in one frame: start bit, data bits, trailing bits
    localparam int unsigned FRAME_BITS = 11;
    localparam int unsigned POS_W      = $clog2(FRAME_BITS);

    // Timer ticks per microsecond
    localparam int unsigned TICKS_PER_US = 50;

    // Nominal intervals in microseconds
    localparam int unsigned NOM_W      = 10;
    localparam logic [NOM_W-1:0] NOM_FULL_ZERO = NOM_W'(417);
    localparam logic [NOM_W-1:0] NOM_FULL_ONE  = NOM_W'(833);
    localparam logic [NOM_W-1:0] NOM_HALF_ZERO = NOM_W'(208);
    localparam logic [NOM_W-1:0] NOM_HALF_ONE  = NOM_W'(417);

    // Bounds in ticks need one bit more than the input
    localparam int unsigned BOUND_W = TICKS_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE = CFG_IDX_W'(0),
        REG_TOL  = CFG_IDX_W'(1)
    } t_reg_idx;

    typedef enum logic {
        MODE_FULL = 1'b0,
        MODE_HALF = 1'b1
    } t_mode;

    // Strict window nom-tol < ticks/50 < nom+tol, evaluated on raw ticks so no
    // divider is needed: t < A  <=>  ticks < 50*A,  t > B  <=>  ticks >= 50*(B+1).
    function automatic logic in_window(
        input logic [TICKS_W-1:0] ticks,
        input logic [NOM_W-1:0]   nom,
        input logic [TOL_W-1:0]   tol
    );
        logic [NOM_W:0]       hi_us;
        logic [NOM_W:0]       lo_us;
        logic [BOUND_W-1:0]   hi_ticks;
        logic [BOUND_W-1:0]   lo_ticks;
        logic                 below_hi;
        logic                 above_lo;
        hi_us    = {1'b0, nom} + {{(NOM_W + 1 - TOL_W){1'b0}}, tol};
        lo_us    = {1'b0, nom} - {{(NOM_W + 1 - TOL_W){1'b0}}, tol} + (NOM_W + 1)'(1);
        hi_ticks = BOUND_W'(hi_us) * BOUND_W'(TICKS_PER_US);
        lo_ticks = BOUND_W'(lo_us) * BOUND_W'(TICKS_PER_US);
        below_hi = {1'b0, ticks} < hi_ticks;
        // Lower bound below zero passes every short interval
        if ({{(NOM_W - TOL_W){1'b0}}, tol} > nom) begin
            above_lo = 1'b1;
        end else begin
            above_lo = {1'b0, ticks} >= lo_ticks;
        end
        return below_hi && above_lo;
    endfunction

endpackage

[sv/fsk_interval_demodulator_top.sv]
// Top level of the FSK interval demodulator: input register, classifier, framer, output register.
//
//  channel   signals                                   direction  payload
//  -------   ----------------------------------------  ---------  ----------------------
//  in        i_in_valid / o_in_ready                   in         i_interval_ticks [15:0]
//  out       o_out_valid / i_out_ready                 out        o_data_byte [7:0]
//  cfg       i_cfg_valid / o_cfg_ready                 in         i_cfg_index, i_cfg_data
//
// One interval enters per cycle. Each transfer lands in an input register; as it
// leaves, the block classifies it, updates the repeat counters and the frame, and
// loads the output register when a frame completes, so a byte passes the input and
// output registers after the transfer that closes its frame. The only stall is a full
// output register that is not being drained: the input stage then holds, and o_in_ready
// drops once it is occupied. Synchronous active-low reset returns mode to half-period,
// tolerance to 50 us and the framer to idle; the cfg channel is always ready.
module fsk_interval_demodulator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [fskid_pkg::TICKS_W-1:0]     i_interval_ticks,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [fskid_pkg::BYTE_W-1:0]      o_data_byte,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fskid_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fskid_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fskid_pkg::*;

    // Configuration
    t_mode              r_mode;
    logic [TOL_W-1:0]   r_tol;

    // Input stage
    logic               r_in_valid;
    logic [TICKS_W-1:0] r_ticks;

    // Demodulator state
    logic               r_active,    n_active;
    logic [POS_W-1:0]   r_pos,       n_pos;
    logic [FRAME_BITS-1:1] r_frame,  n_frame;
    logic [1:0]         r_zero_rep,  n_zero_rep;
    logic               r_one_rep,   n_one_rep;
    logic               r_toggle,    n_toggle;

    // Output stage
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_byte,      n_byte;

    logic               advance;
    logic               emit;
    logic               win_zero;
    logic               win_one;
    logic               cls_zero;
    logic               cls_one;
    logic               take;
    logic               take_bit;

    assign o_cfg_ready = 1'b1;

    // The item in the input stage moves on when the output slot is free next cycle
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HALF;
            r_tol  <= TOL_W'(50);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE: r_mode <= t_mode'(i_cfg_data[0]);
                REG_TOL:  r_tol  <= i_cfg_data[TOL_W-1:0];
                default:  ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ticks <= i_interval_ticks;
        end
    end

    // Classify against the windows of the current mode; the zero window wins on overlap
    always_comb begin
        if (r_mode == MODE_FULL) begin
            win_zero = in_window(r_ticks, NOM_FULL_ZERO, r_tol);
            win_one  = in_window(r_ticks, NOM_FULL_ONE, r_tol);
        end else begin
            win_zero = in_window(r_ticks, NOM_HALF_ZERO, r_tol);
            win_one  = in_window(r_ticks, NOM_HALF_ONE, r_tol);
        end
    end

    always_comb begin
        n_zero_rep = r_zero_rep;
        n_one_rep  = r_one_rep;
        n_toggle   = r_toggle;
        cls_zero   = 1'b0;
        cls_one    = 1'b0;
        if (r_mode == MODE_FULL) begin
            // Every other zero interval is skipped through the toggle
            if (win_zero) begin
                n_toggle = !r_toggle;
                cls_zero = 1'b1;
            end else if (win_one) begin
                cls_one = 1'b1;
            end
        end else begin
            // Suppress repeat intervals inside one bit time
            if (win_zero) begin
                cls_zero   = (r_zero_rep == 2'd0);
                n_one_rep  = 1'b0;
                n_zero_rep = r_zero_rep + 2'd1;
            end else if (win_one) begin
                cls_one    = !r_one_rep;
                n_zero_rep = 2'd0;
                n_one_rep  = !r_one_rep;
            end else begin
                n_one_rep  = 1'b0;
            end
        end
    end

    assign take     = (cls_zero && !n_toggle) || (cls_one && r_active);
    assign take_bit = !(cls_zero && !n_toggle);

    // Framer: a zero starts a frame, later bits fill positions 1 and up
    always_comb begin
        n_active = r_active;
        n_pos    = r_pos;
        n_frame  = r_frame;
        emit     = 1'b0;
        if (take) begin
            if (!r_active) begin
                n_active = 1'b1;
                n_pos    = POS_W'(1);
            end else begin
                for (int i = 1; i < FRAME_BITS; i++) begin
                    if (r_pos == POS_W'(i)) begin
                        n_frame[i] = take_bit;
                    end
                end
                if (r_pos == POS_W'(FRAME_BITS - 1)) begin
                    emit     = 1'b1;
                    n_active = 1'b0;
                    n_pos    = '0;
                end else begin
                    n_pos    = r_pos + POS_W'(1);
                end
            end
        end
    end

    // First data bit goes to the MSB
    always_comb begin
        for (int i = 0; i < BYTE_W; i++) begin
            n_byte[BYTE_W-1-i] = n_frame[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_pos      <= '0;
            r_zero_rep <= 2'd0;
            r_one_rep  <= 1'b0;
            r_toggle   <= 1'b0;
        end else if (advance) begin
            r_active   <= n_active;
            r_pos      <= n_pos;
            r_zero_rep <= n_zero_rep;
            r_one_rep  <= n_one_rep;
            r_toggle   <= n_toggle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else if (advance) begin
            r_frame <= n_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_byte <= n_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_byte;

endmodule

[dv/fsk_interval_demodulator_top_tb.sv]
// Self-checking testbench for the FSK interval demodulator: random tone frames against a byte predictor.
`timescale 1ns / 100ps

module fsk_interval_demodulator_top_tb;
    import fskid_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 3;
    localparam int SETTLE_CYCLES  = 8;     // byte passes the input and output registers after its closing transfer
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transfer on any channel
    localparam int IDLE_PCT       = 12;
    localparam int MAX_REPORTS    = 10;
    localparam int NUM_SETTINGS   = 10;
    localparam int EXTRA_PHASES   = 10;
    localparam int PHASE_ITEMS    = 160;
    localparam int MIN_BYTES      = 48;
    localparam int QUIET_PHASE    = 4;
    localparam int MAX_NOISE_US   = 1300;

    // Register settings walked through in order: reset values, zero and full tolerance,
    // a one-microsecond window, and overlapping zero/one windows in full-period timing.
    localparam t_mode SET_MODE [NUM_SETTINGS] = '{
        MODE_HALF, MODE_FULL, MODE_HALF, MODE_FULL, MODE_HALF,
        MODE_FULL, MODE_HALF, MODE_FULL, MODE_HALF, MODE_FULL
    };
    localparam logic [TOL_W-1:0] SET_TOL [NUM_SETTINGS] = '{
        8'd50, 8'd50, 8'd0, 8'd255, 8'd255, 8'd20, 8'd100, 8'd209, 8'd1, 8'd60
    };

    typedef enum logic [1:0] {
        TONE_ZERO,
        TONE_ONE,
        TONE_NONE
    } t_tone;

    // Tracks register values and framer state; holds the bytes still owed by the block.
    class byte_scoreboard;
        t_mode              mode;
        logic [TOL_W-1:0]   tol;
        logic               in_frame;
        int unsigned        bit_pos;
        logic [15:0]        frame_bits;
        logic [1:0]         zero_run;
        logic               one_run;
        logic               zero_skip;
        logic [BYTE_W-1:0]  expected_bytes [$];
        int unsigned        bytes_predicted;
        int unsigned        mismatches;

        function new();
            mode            = MODE_HALF;
            tol             = 8'd50;
            in_frame        = 1'b0;
            bit_pos         = 0;
            frame_bits      = '0;
            zero_run        = '0;
            one_run         = 1'b0;
            zero_skip       = 1'b0;
            bytes_predicted = 0;
            mismatches      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MODE) begin
                mode = t_mode'(data[0]);
            end else if (idx == REG_TOL) begin
                tol = data;
            end
        endfunction

        // Strict window; a negative lower bound passes every short interval
        function bit in_win(int t, int nom);
            return (t < nom + int'(tol)) && (t > nom - int'(tol));
        endfunction

        function t_tone classify(int t);
            logic lead;
            if (mode == MODE_FULL) begin
                if (in_win(t, int'(NOM_FULL_ZERO))) begin
                    zero_skip = ~zero_skip;
                    return TONE_ZERO;
                end
                if (in_win(t, int'(NOM_FULL_ONE))) begin
                    return TONE_ONE;
                end
                return TONE_NONE;
            end
            if (in_win(t, int'(NOM_HALF_ZERO))) begin
                lead     = (zero_run == 2'd0);
                one_run  = 1'b0;
                zero_run = zero_run + 2'd1;
                return lead ? TONE_ZERO : TONE_NONE;
            end
            if (in_win(t, int'(NOM_HALF_ONE))) begin
                lead     = ~one_run;
                zero_run = 2'd0;
                one_run  = ~one_run;
                return lead ? TONE_ONE : TONE_NONE;
            end
            one_run = 1'b0;
            return TONE_NONE;
        endfunction

        function void note_interval(logic [TICKS_W-1:0] ticks);
            t_tone             tone;
            logic              take;
            logic              one_bit;
            logic [BYTE_W-1:0] b;
            tone    = classify(int'(ticks) / int'(TICKS_PER_US));
            take    = 1'b0;
            one_bit = 1'b0;
            if (tone == TONE_ZERO && !zero_skip) begin
                take = 1'b1;
            end else if (tone == TONE_ONE && in_frame) begin
                take    = 1'b1;
                one_bit = 1'b1;
            end
            if (!take) begin
                return;
            end
            // Idle: an accepted zero is the start bit
            if (!in_frame) begin
                in_frame      = 1'b1;
                frame_bits[0] = 1'b0;
                bit_pos       = 1;
                return;
            end
            frame_bits[bit_pos] = one_bit;
            if (bit_pos + 1 >= FRAME_BITS) begin
                for (int i = 0; i < BYTE_W; i++) begin
                    b[BYTE_W-1-i] = frame_bits[i+1];
                end
                expected_bytes.push_back(b);
                bytes_predicted++;
                bit_pos  = 0;
                in_frame = 1'b0;
            end else begin
                bit_pos++;
            end
        endfunction

        function void check_byte(logic [BYTE_W-1:0] got);
            logic [BYTE_W-1:0] want;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: data_byte 0x%02h with no byte pending", $realtime, got);
                end
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: data_byte mismatch: expected 0x%02h, got 0x%02h",
                             $realtime, want, got);
                end
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [TICKS_W-1:0]     in_ticks = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [BYTE_W-1:0]      data_byte;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    byte_scoreboard sb = new();
    int unsigned    sent_count = 0;
    int unsigned    quiet_cycles = 0;
    bit             quiet = 1'b0;   // suppress idling on both sides

    fsk_interval_demodulator_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_interval_ticks (in_ticks),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_data_byte      (data_byte),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        forever begin
            #(CLK_HALF) clk = ~clk;
        end
    end

    // Stall the byte output at random unless a quiet stretch is running
    always @(posedge clk) begin
        out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Observe every transfer at the edge that completes it; values read here are
    // the ones the block sampled. Count edges with no transfer for the watchdog.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                sb.note_interval(in_ticks);
            end
            if (out_valid && out_ready) begin
                sb.check_byte(data_byte);
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Present one interval, sometimes after a short gap, and hold it until the transfer
    task automatic send_interval(input logic [TICKS_W-1:0] ticks);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_ticks <= ticks;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    // Drop the input, wait for every owed byte, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_bytes.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Valid stays high across the writes of one burst; the caller raises and drops it
    task automatic cfg_transfer(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
    endtask

    // Write both registers, plus an index that must be ignored; upper mode bits are junk
    task automatic configure(input t_mode m, input logic [TOL_W-1:0] tol);
        cfg_valid <= 1'b1;
        cfg_transfer(CFG_IDX_W'($urandom_range(int'(REG_TOL) + 1, 2**CFG_IDX_W - 1)),
                     CFG_DATA_W'($urandom));
        cfg_transfer(REG_MODE, {7'($urandom_range(0, 127)), m});
        cfg_transfer(REG_TOL, tol);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_nominal();
        case ($urandom_range(0, 2))
            0:       return int'(NOM_HALF_ZERO);
            1:       return int'(NOM_FULL_ZERO);
            default: return int'(NOM_FULL_ONE);
        endcase
    endfunction

    // Junk intervals: anywhere, short, right at a window bound, or the field extremes
    function automatic logic [TICKS_W-1:0] noise_ticks();
        int                 t;
        logic [TICKS_W-1:0] ticks;
        case ($urandom_range(0, 3))
            0: ticks = TICKS_W'($urandom_range(0, 65535));
            1: ticks = TICKS_W'($urandom_range(0, 30000));
            2: begin
                t = pick_nominal();
                t = $urandom_range(0, 1) ? t + int'(sb.tol) : t - int'(sb.tol);
                t = t + int'($urandom_range(0, 2)) - 1;
                t = (t < 0) ? 0 : ((t > MAX_NOISE_US) ? MAX_NOISE_US : t);
                ticks = TICKS_W'(t * int'(TICKS_PER_US) + int'($urandom_range(0, 49)));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       ticks = '0;
                    1:       ticks = '1;
                    2:       ticks = TICKS_W'(TICKS_PER_US - 1);
                    default: ticks = TICKS_W'(TICKS_PER_US);
                endcase
            end
        endcase
        return ticks;
    endfunction

    // An interval inside the window around nom, often on its lowest or highest microsecond
    function automatic logic [TICKS_W-1:0] window_ticks(input int nom);
        int tol;
        int lo;
        int hi;
        int t;
        tol = int'(sb.tol);
        if (tol == 0) begin
            return noise_ticks();
        end
        lo = (nom - tol + 1 < 0) ? 0 : nom - tol + 1;
        hi = nom + tol - 1;
        case ($urandom_range(0, 7))
            0:       t = lo;
            1:       t = hi;
            default: t = int'($urandom_range(lo, hi));
        endcase
        return TICKS_W'(t * int'(TICKS_PER_US) + int'($urandom_range(0, TICKS_PER_US - 1)));
    endfunction

    // One bit time of tone: a zero spans four half periods or two periods, a one half that
    task automatic send_tone(input logic one_bit);
        int nom;
        int count;
        if (sb.mode == MODE_HALF) begin
            nom   = one_bit ? int'(NOM_HALF_ONE) : int'(NOM_HALF_ZERO);
            count = one_bit ? 2 : 4;
        end else begin
            nom   = one_bit ? int'(NOM_FULL_ONE) : int'(NOM_FULL_ZERO);
            count = one_bit ? 1 : 2;
        end
        repeat (count) send_interval(window_ticks(nom));
    endtask

    // Mark idle, start bit, eight data bits MSB first, two stop bits. A broken frame
    // loses one bit or gets a junk interval in front of it.
    task automatic send_frame(input bit broken);
        logic [FRAME_BITS-1:0] frame;
        int                    bad;
        frame = {1'b0, 8'($urandom), 2'b11};
        bad   = broken ? int'($urandom_range(0, FRAME_BITS - 1)) : -1;
        repeat ($urandom_range(0, 2)) send_tone(1'b1);
        for (int i = FRAME_BITS - 1; i >= 0; i--) begin
            if (i == bad) begin
                if ($urandom_range(0, 1)) begin
                    continue;
                end
                send_interval(noise_ticks());
            end
            send_tone(frame[i]);
        end
    endtask

    task automatic run_random(input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        start = sent_count;
        while (sent_count - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(1'b0);
            end else if (pick < 85) begin
                send_frame(1'b1);
            end else begin
                repeat ($urandom_range(1, 4)) send_interval(noise_ticks());
            end
        end
    endtask

    // Reset settings, half-period timing: field extremes, ones while idle, both strict
    // bounds of each window, a start bit and repeat suppression of both tones.
    task automatic run_directed();
        logic [TICKS_W-1:0] seq [16] = '{
            16'd0, 16'd65535, 16'd49, 16'd50,
            16'd20850, 16'd20850,
            16'd12900, 16'd7900, 16'd7950, 16'd12899, 16'd12850,
            16'd18350, 16'd23350, 16'd23349, 16'd18300, 16'd10400
        };
        foreach (seq[i]) begin
            send_interval(seq[i]);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        settle();

        // Walk the table, then keep going with random settings until enough bytes came out
        for (int p = 0; p < NUM_SETTINGS + EXTRA_PHASES; p++) begin
            if (p >= NUM_SETTINGS && sb.bytes_predicted >= MIN_BYTES) begin
                break;
            end
            if (p < NUM_SETTINGS) begin
                configure(SET_MODE[p], SET_TOL[p]);
            end else begin
                configure(t_mode'($urandom_range(0, 1)), TOL_W'($urandom_range(20, 120)));
            end
            quiet = (p == QUIET_PHASE);
            run_random(PHASE_ITEMS);
            settle();
        end

        if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
